>>> design/bpu_pkg.sv
// bitmap pixel unpacker: shared constants, format and register codes,
// palette color conversion. No dependencies.
package bpu_pkg;

    localparam int COORD_BITS   = 12;
    localparam int PAL_DEPTH    = 256;
    localparam int PAL_AW       = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;

    localparam int FMT_BITS     = 3;
    localparam int DIM_BITS     = 13;
    localparam int BYTE_BITS    = 8;
    localparam int PIDX_BITS    = 8;
    localparam int PCOLOR_BITS  = 24;
    localparam int PIXEL_BITS   = 32;
    localparam int CFG_IDX_BITS = 2;

    // counters that must hold the dimension itself
    localparam int CNT_BITS = COORD_BITS + 1;
    localparam int EXT_BITS = (CNT_BITS > DIM_BITS) ? CNT_BITS : DIM_BITS;
    localparam logic [EXT_BITS-1:0] COORD_LIMIT = EXT_BITS'(1) << COORD_BITS;

    localparam logic [7:0] ALPHA = 8'hFF;

    typedef logic [FMT_BITS-1:0] fmt_t;
    localparam fmt_t FMT_1BPP  = 3'd0;
    localparam fmt_t FMT_4BPP  = 3'd1;
    localparam fmt_t FMT_8BPP  = 3'd2;
    localparam fmt_t FMT_24BPP = 3'd3;
    localparam fmt_t FMT_32BPP = 3'd4;

    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_FORMAT = 2'd0;
    localparam cfg_idx_t REG_WIDTH  = 2'd1;
    localparam cfg_idx_t REG_HEIGHT = 2'd2;

    // stored entry is red 7:0, green 15:8, blue 23:16
    function automatic logic [PIXEL_BITS-1:0] pal_to_argb(input logic [PCOLOR_BITS-1:0] c);
        pal_to_argb = {ALPHA, c[7:0], c[15:8], c[23:16]};
    endfunction

endpackage

>>> design/bpu_in_if.sv
// bitmap pixel unpacker: input channel (pixel bytes and palette writes)
// depends on bpu_pkg
interface bpu_in_if;
    import bpu_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   func;
    logic [BYTE_BITS-1:0]   data_byte;
    logic [PIDX_BITS-1:0]   palette_index;
    logic [PCOLOR_BITS-1:0] palette_color;

    modport source (output valid, func, data_byte, palette_index, palette_color,
                    input ready);
    modport sink   (input valid, func, data_byte, palette_index, palette_color,
                    output ready);
endinterface

>>> design/bpu_out_if.sv
// bitmap pixel unpacker: pixel output channel
// depends on bpu_pkg
interface bpu_out_if;
    import bpu_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_color;
    logic [COORD_BITS-1:0] pixel_column;
    logic [COORD_BITS-1:0] pixel_row;
    logic                  last_of_run;
    logic                  last_of_image;

    modport source (output valid, pixel_color, pixel_column, pixel_row,
                    last_of_run, last_of_image, input ready);
    modport sink   (input valid, pixel_color, pixel_column, pixel_row,
                    last_of_run, last_of_image, output ready);
endinterface

>>> design/bpu_cfg_if.sv
// bitmap pixel unpacker: configuration write channel
// depends on bpu_pkg
interface bpu_cfg_if;
    import bpu_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [DIM_BITS-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/bitmap_pixel_unpacker_top.sv
// bitmap pixel unpacker top level: byte hold stage, palette memory, pixel output register
// depends on bpu_pkg, bpu_in_if, bpu_out_if, bpu_cfg_if
//
//  channel  | dir | payload                                              | word
//  pix_in   | in  | func, data_byte, palette_index, palette_color        | byte or palette write
//  pix_out  | out | pixel_color, pixel_column, pixel_row, last_of_run,   | one pixel
//           |     | last_of_image                                        |
//  cfg      | in  | index, data                                          | register write
//
// with no output stall, a word is taken every cycle at 8, 24 and 32 bpp and for palette writes;
// at 1 bpp a byte holds the hold stage for up to 8 pixels, at 4 bpp for 2 (one pixel per cycle)
// from accept to pixel valid: the hold stage, then the output and palette read registers
// the hold stage frees in the cycle of its last pixel, so the next word is taken then
// reset: format 8 bpp, width 1, height 1, stream position cleared; palette contents unknown
// output stall freezes the output register and the palette read; the hold stage waits behind it
module bitmap_pixel_unpacker_top (
    input  logic       clk,
    input  logic       rst_n,
    bpu_in_if.sink     pix_in,
    bpu_out_if.source  pix_out,
    bpu_cfg_if.sink    cfg
);
    import bpu_pkg::*;

    // configuration registers
    fmt_t                fmt_reg;
    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;

    // hold stage
    logic                   hold_valid_reg, hold_valid_next;
    logic                   hold_func_reg;
    logic [BYTE_BITS-1:0]   hold_byte_reg;
    logic [PIDX_BITS-1:0]   hold_pidx_reg;
    logic [PCOLOR_BITS-1:0] hold_pcol_reg;
    logic [2:0]             sub_reg, sub_next;

    // stream position
    logic [COORD_BITS-1:0]  col_reg, col_next;
    logic [COORD_BITS-1:0]  row_reg, row_next;
    logic [1:0]             phase_reg, phase_next;
    logic [PCOLOR_BITS-1:0] partial_reg, partial_next;
    logic [1:0]             pad_reg, pad_next;
    logic                   done_reg, done_next;

    // output stage
    logic                   s2_valid_reg;
    logic                   s2_use_pal_reg;
    logic [PIXEL_BITS-1:0]  s2_direct_reg;
    logic [COORD_BITS-1:0]  s2_col_reg;
    logic [COORD_BITS-1:0]  s2_row_reg;
    logic                   s2_lrun_reg;
    logic                   s2_limg_reg;
    logic [PCOLOR_BITS-1:0] pal_q_reg;

    logic [PCOLOR_BITS-1:0] pal_mem [PAL_DEPTH];

    logic [EXT_BITS-1:0]  width_x, height_x;
    logic [CNT_BITS-1:0]  w_eff, h_eff;
    logic [CNT_BITS-1:0]  col_inc, row_inc;
    logic                 row_end, img_end;
    logic [COORD_BITS-1:0] out_row;

    logic                 emit, use_pal, last_sub, final_step;
    logic                 step_go, step_done, s2_ready, in_fire;
    logic                 pal_we, pal_re;
    logic [PIDX_BITS-1:0] rd_idx;
    logic [PIXEL_BITS-1:0] direct_color;
    logic                 restart;

    assign width_x  = EXT_BITS'(width_reg);
    assign height_x = EXT_BITS'(height_reg);

    always_comb
    begin
        if (width_x == '0)
            w_eff = CNT_BITS'(1);
        else if (width_x > COORD_LIMIT)
            w_eff = CNT_BITS'(COORD_LIMIT);
        else
            w_eff = CNT_BITS'(width_x);
        if (height_x == '0)
            h_eff = CNT_BITS'(1);
        else if (height_x > COORD_LIMIT)
            h_eff = CNT_BITS'(COORD_LIMIT);
        else
            h_eff = CNT_BITS'(height_x);
    end

    assign col_inc = CNT_BITS'(col_reg) + CNT_BITS'(1);
    assign row_inc = CNT_BITS'(row_reg) + CNT_BITS'(1);
    assign row_end = (col_inc >= w_eff);
    assign img_end = row_end && (row_inc >= h_eff);
    assign out_row = COORD_BITS'(h_eff - CNT_BITS'(1) - CNT_BITS'(row_reg));

    assign s2_ready = !s2_valid_reg || pix_out.ready;

    // one step of the held word: at most one pixel
    always_comb
    begin
        emit         = 1'b0;
        use_pal      = 1'b0;
        last_sub     = 1'b1;
        rd_idx       = hold_byte_reg;
        direct_color = '0;
        phase_next   = phase_reg;
        partial_next = partial_reg;
        pad_next     = pad_reg;
        pal_we       = 1'b0;

        if (hold_valid_reg && hold_func_reg) begin
            pal_we = ({1'b0, hold_pidx_reg} < (PIDX_BITS+1)'(PAL_DEPTH));
        end
        else if (!hold_valid_reg || done_reg || fmt_reg > FMT_32BPP) begin
            emit = 1'b0;
        end
        else if (pad_reg != 2'd0) begin
            pad_next = pad_reg - 2'd1;
        end
        else begin
            case (fmt_reg)
                FMT_1BPP:
                begin
                    emit     = 1'b1;
                    use_pal  = 1'b1;
                    rd_idx   = {{(PIDX_BITS-1){1'b0}}, hold_byte_reg[3'd7 - sub_reg]};
                    last_sub = (sub_reg == 3'd7);
                end
                FMT_4BPP:
                begin
                    emit     = 1'b1;
                    use_pal  = 1'b1;
                    rd_idx   = sub_reg[0] ? {4'd0, hold_byte_reg[3:0]}
                                          : {4'd0, hold_byte_reg[7:4]};
                    last_sub = sub_reg[0];
                end
                FMT_8BPP:
                begin
                    emit    = 1'b1;
                    use_pal = 1'b1;
                end
                FMT_24BPP:
                begin
                    if (phase_reg >= 2'd2) begin
                        emit         = 1'b1;
                        direct_color = {ALPHA, partial_reg[7:0], partial_reg[15:8],
                                        hold_byte_reg};
                        phase_next   = 2'd0;
                        partial_next = '0;
                    end
                    else begin
                        partial_next = partial_reg |
                            (PCOLOR_BITS'(hold_byte_reg) << {phase_reg, 3'b000});
                        phase_next   = phase_reg + 2'd1;
                    end
                end
                FMT_32BPP:
                begin
                    if (phase_reg == 2'd3) begin
                        emit         = 1'b1;
                        direct_color = {ALPHA, partial_reg[7:0], partial_reg[15:8],
                                        partial_reg[23:16]};
                        phase_next   = 2'd0;
                        partial_next = '0;
                    end
                    else begin
                        partial_next = partial_reg |
                            (PCOLOR_BITS'(hold_byte_reg) << {phase_reg, 3'b000});
                        phase_next   = phase_reg + 2'd1;
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end

        // palette miss reads as opaque black
        if (use_pal && !({1'b0, rd_idx} < (PIDX_BITS+1)'(PAL_DEPTH))) begin
            use_pal      = 1'b0;
            direct_color = {ALPHA, 24'd0};
        end

        col_next  = col_reg;
        row_next  = row_reg;
        done_next = done_reg;
        if (emit) begin
            col_next = col_inc[COORD_BITS-1:0];
            if (row_end) begin
                col_next  = '0;
                row_next  = row_inc[COORD_BITS-1:0];
                done_next = img_end;
                if (fmt_reg == FMT_8BPP)
                    pad_next = 2'd0 - w_eff[1:0];
                else if (fmt_reg == FMT_24BPP)
                    pad_next = 2'd0 - 2'(w_eff[1:0] * 2'd3);
                else
                    pad_next = 2'd0;
            end
        end
    end

    assign final_step = !emit || last_sub || row_end;
    assign step_go    = hold_valid_reg && (!emit || s2_ready);
    assign step_done  = step_go && final_step;
    assign pal_re     = step_go && emit && use_pal;
    assign sub_next   = step_done ? 3'd0 : (step_go ? sub_reg + 3'd1 : sub_reg);

    assign pix_in.ready = !hold_valid_reg || step_done;
    assign in_fire      = pix_in.valid && pix_in.ready;
    assign hold_valid_next = in_fire ? 1'b1 : (step_done ? 1'b0 : hold_valid_reg);

    assign cfg.ready = 1'b1;
    assign restart   = cfg.valid && (cfg.index == REG_FORMAT || cfg.index == REG_WIDTH
                                     || cfg.index == REG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fmt_reg        <= FMT_8BPP;
            width_reg      <= DIM_BITS'(1);
            height_reg     <= DIM_BITS'(1);
            hold_valid_reg <= 1'b0;
            sub_reg        <= 3'd0;
            col_reg        <= '0;
            row_reg        <= '0;
            phase_reg      <= 2'd0;
            partial_reg    <= '0;
            pad_reg        <= 2'd0;
            done_reg       <= 1'b0;
            s2_valid_reg   <= 1'b0;
        end
        else begin
            hold_valid_reg <= hold_valid_next;
            sub_reg        <= sub_next;
            if (s2_ready)
                s2_valid_reg <= step_go && emit;
            if (restart) begin
                case (cfg.index)
                    REG_FORMAT: fmt_reg    <= cfg.data[FMT_BITS-1:0];
                    REG_WIDTH:  width_reg  <= cfg.data;
                    REG_HEIGHT: height_reg <= cfg.data;
                    default:    fmt_reg    <= fmt_reg;
                endcase
                col_reg     <= '0;
                row_reg     <= '0;
                phase_reg   <= 2'd0;
                partial_reg <= '0;
                pad_reg     <= 2'd0;
                done_reg    <= 1'b0;
            end
            else if (step_go) begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                phase_reg   <= phase_next;
                partial_reg <= partial_next;
                pad_reg     <= pad_next;
                done_reg    <= done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            hold_func_reg <= pix_in.func;
            hold_byte_reg <= pix_in.data_byte;
            hold_pidx_reg <= pix_in.palette_index;
            hold_pcol_reg <= pix_in.palette_color;
        end
        if (step_go && emit) begin
            s2_use_pal_reg <= use_pal;
            s2_direct_reg  <= direct_color;
            s2_col_reg     <= col_reg;
            s2_row_reg     <= out_row;
            s2_lrun_reg    <= final_step;
            s2_limg_reg    <= img_end;
        end
    end

    // palette memory, registered read
    always_ff @(posedge clk)
    begin
        if (pal_we)
            pal_mem[hold_pidx_reg[PAL_AW-1:0]] <= hold_pcol_reg;
        if (pal_re)
            pal_q_reg <= pal_mem[rd_idx[PAL_AW-1:0]];
    end

    assign pix_out.valid         = s2_valid_reg;
    assign pix_out.pixel_color   = s2_use_pal_reg ? pal_to_argb(pal_q_reg) : s2_direct_reg;
    assign pix_out.pixel_column  = s2_col_reg;
    assign pix_out.pixel_row     = s2_row_reg;
    assign pix_out.last_of_run   = s2_lrun_reg;
    assign pix_out.last_of_image = s2_limg_reg;

`ifndef SYNTHESIS
    // stalled output keeps the pixel, including the palette read data
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !pix_out.ready |=> s2_valid_reg && $stable(pix_out.pixel_color)
            && $stable(s2_col_reg) && $stable(s2_row_reg))
        else $error("output pixel changed while stalled");

    a_no_pix_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && hold_valid_reg && !hold_func_reg |-> !emit)
        else $error("pixel produced after end of image");

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_BITS'(col_reg) < w_eff)
        else $error("column counter beyond row width");

    a_img_implies_run: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_limg_reg |-> s2_lrun_reg)
        else $error("last of image without last of run");

    a_phase_24: assert property (@(posedge clk) disable iff (!rst_n)
        fmt_reg == FMT_24BPP |-> phase_reg != 2'd3)
        else $error("byte phase out of range at 24 bpp");
`endif

endmodule

>>> test/tb_bitmap_pixel_unpacker_top.sv
// testbench for bitmap_pixel_unpacker_top: streams palette writes and pixel bytes
// through all formats, predicts each pixel and checks the output words in order
// depends on bpu_pkg, bpu_in_if, bpu_out_if, bpu_cfg_if and the top level
module tb_bitmap_pixel_unpacker_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bpu_pkg::*;

    localparam int       WATCHDOG_LIMIT  = 2000;
    localparam int       LONG_HOLD       = 300;
    localparam int       SETTLE          = 6;
    localparam int       MAX_GAP         = 12;
    localparam int       MAX_PRINTS      = 40;
    localparam int       RANDOM_BYTES    = 48;
    localparam int       DIM_MAX         = 1 << COORD_BITS;
    localparam cfg_idx_t REG_SPARE       = 2'd3;
    localparam fmt_t     FMT_UNDEF_FIRST = 3'd5;
    localparam fmt_t     FMT_UNDEF_LAST  = 3'd7;
    localparam bit       FUNC_PIXEL      = 1'b0;
    localparam bit       FUNC_PALETTE    = 1'b1;

    typedef struct packed {
        logic                   func;
        logic [BYTE_BITS-1:0]   data;
        logic [PIDX_BITS-1:0]   pidx;
        logic [PCOLOR_BITS-1:0] pcolor;
    } in_word_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] color;
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        logic                  last_run;
        logic                  last_image;
    } pixel_t;

    logic clk;
    logic rst_n;

    bpu_in_if  pix_in ();
    bpu_out_if pix_out ();
    bpu_cfg_if cfg ();

    bitmap_pixel_unpacker_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .cfg     (cfg)
    );

    in_word_t word_queue[$];
    pixel_t   expected_pixels[$];
    in_word_t offered_word;
    int       words_queued;
    int       words_taken;
    int       err_count;
    int       in_gap_max;
    int       out_gap_max;
    int       in_wait;
    int       out_wait;
    int       hold_left;
    bit       offering;
    bit       long_hold;
    // handshake seen at the rising edge, consumed at the next falling edge
    bit       in_took;
    bit       out_took;

    // unpacker model state
    logic [PCOLOR_BITS-1:0] pal_mem [PAL_DEPTH];
    fmt_t                   cur_fmt;
    logic [DIM_BITS-1:0]    cur_width;
    logic [DIM_BITS-1:0]    cur_height;
    int                     col_pos;
    int                     row_pos;
    int                     byte_phase;
    int                     pad_left;
    logic [23:0]            partial;
    bit                     img_done;

    // stimulus side: palette entries already written, format being generated
    bit   pal_written [PAL_DEPTH];
    fmt_t gen_fmt;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_dim(logic [DIM_BITS-1:0] v);
        if (v == 0)
            return 1;
        if (v > DIM_MAX)
            return DIM_MAX;
        return int'(v);
    endfunction

    function automatic logic [PIXEL_BITS-1:0] palette_argb(logic [BYTE_BITS-1:0] idx);
        logic [PCOLOR_BITS-1:0] e;
        if (idx >= PAL_DEPTH)
            return {8'hFF, 24'h0};
        e = pal_mem[idx];
        return {8'hFF, e[7:0], e[15:8], e[23:16]};
    endfunction

    // queues one pixel at the current position; returns 1 when its row ends
    function automatic bit emit_pixel(logic [PIXEL_BITS-1:0] color);
        int     w;
        int     h;
        bit     row_end;
        pixel_t p;
        w = clamp_dim(cur_width);
        h = clamp_dim(cur_height);
        p.color = color;
        p.column = COORD_BITS'(col_pos);
        p.row = COORD_BITS'(h - 1 - row_pos);
        p.last_run = 1'b0;
        p.last_image = 1'b0;
        row_end = 1'b0;
        col_pos++;
        if (col_pos >= w)
        begin
            row_end = 1'b1;
            col_pos = 0;
            row_pos++;
            if (cur_fmt == FMT_8BPP)
                pad_left = (4 - (w & 3)) & 3;
            else if (cur_fmt == FMT_24BPP)
                pad_left = (4 - ((3 * w) & 3)) & 3;
            else
                pad_left = 0;
            if (row_pos >= h)
            begin
                img_done = 1'b1;
                p.last_image = 1'b1;
            end
        end
        expected_pixels.push_back(p);
        return row_end;
    endfunction

    function automatic void apply_reg(cfg_idx_t idx, logic [DIM_BITS-1:0] val);
        case (idx)
            REG_FORMAT: cur_fmt = val[FMT_BITS-1:0];
            REG_WIDTH:  cur_width = val;
            REG_HEIGHT: cur_height = val;
            default:    return;
        endcase
        col_pos = 0;
        row_pos = 0;
        byte_phase = 0;
        partial = '0;
        pad_left = 0;
        img_done = 1'b0;
    endfunction

    function automatic void unpack_word(in_word_t wd);
        int                    base;
        int                    s;
        logic [BYTE_BITS-1:0]  b;
        logic [PIXEL_BITS-1:0] color;
        pixel_t                p;
        b = wd.data;
        base = expected_pixels.size();
        if (wd.func == FUNC_PALETTE)
        begin
            if (wd.pidx < PAL_DEPTH)
                pal_mem[wd.pidx] = wd.pcolor;
            return;
        end
        if (img_done || cur_fmt > FMT_32BPP)
            return;
        if (pad_left > 0)
        begin
            pad_left--;
            return;
        end
        case (cur_fmt)
            FMT_1BPP:
            begin
                for (s = 7; s >= 0; s--)
                    if (emit_pixel(palette_argb(BYTE_BITS'(b[s]))))
                        break;
            end
            FMT_4BPP:
            begin
                if (!emit_pixel(palette_argb(BYTE_BITS'(b[7:4]))))
                    void'(emit_pixel(palette_argb(BYTE_BITS'(b[3:0]))));
            end
            FMT_8BPP:
                void'(emit_pixel(palette_argb(b)));
            FMT_24BPP:
            begin
                if (byte_phase >= 2)
                begin
                    color = {8'hFF, partial[7:0], partial[15:8], b};
                    byte_phase = 0;
                    partial = '0;
                    void'(emit_pixel(color));
                end
                else
                begin
                    partial = partial | (24'(b) << (8 * byte_phase));
                    byte_phase++;
                end
            end
            default:
            begin
                if (byte_phase >= 3)
                begin
                    color = {8'hFF, partial[7:0], partial[15:8], partial[23:16]};
                    byte_phase = 0;
                    partial = '0;
                    void'(emit_pixel(color));
                end
                else
                begin
                    partial = partial | (24'(b) << (8 * byte_phase));
                    byte_phase++;
                end
            end
        endcase
        if (expected_pixels.size() > base)
        begin
            p = expected_pixels.pop_back();
            p.last_run = 1'b1;
            expected_pixels.push_back(p);
        end
    endfunction

    task automatic report(string what, logic [PIXEL_BITS-1:0] want, logic [PIXEL_BITS-1:0] got);
        if (err_count < MAX_PRINTS)
            $display("%0t ns mismatch on %s: expected %h, got %h", $time, what, want, got);
        err_count++;
    endtask

    // stimulus builders: they only queue words for the driver
    function automatic void push_word(bit f, logic [BYTE_BITS-1:0] d,
                                      logic [PIDX_BITS-1:0] idx, logic [PCOLOR_BITS-1:0] c);
        in_word_t wd;
        wd.func = f;
        wd.data = d;
        wd.pidx = idx;
        wd.pcolor = c;
        word_queue.push_back(wd);
        words_queued++;
    endfunction

    function automatic void add_palette(logic [PIDX_BITS-1:0] idx, logic [PCOLOR_BITS-1:0] c);
        push_word(FUNC_PALETTE, BYTE_BITS'($urandom), idx, c);
        if (idx < PAL_DEPTH)
            pal_written[idx] = 1'b1;
    endfunction

    function automatic void need_entry(logic [PIDX_BITS-1:0] idx);
        if (!pal_written[idx])
            add_palette(idx, PCOLOR_BITS'($urandom));
    endfunction

    // a pixel byte, preceded by writes of any palette entry it could read
    function automatic void add_byte(logic [BYTE_BITS-1:0] b);
        case (gen_fmt)
            FMT_1BPP:
            begin
                need_entry(8'd0);
                need_entry(8'd1);
            end
            FMT_4BPP:
            begin
                need_entry(PIDX_BITS'(b[7:4]));
                need_entry(PIDX_BITS'(b[3:0]));
            end
            FMT_8BPP:
                need_entry(b);
            default: ;
        endcase
        push_word(FUNC_PIXEL, b, PIDX_BITS'($urandom), PCOLOR_BITS'($urandom));
    endfunction

    function automatic int image_bytes(fmt_t f, int w, int h);
        int row_len;
        case (f)
            FMT_1BPP:  row_len = (w + 7) / 8;
            FMT_4BPP:  row_len = (w + 1) / 2;
            FMT_8BPP:  row_len = (w + 3) / 4 * 4;
            FMT_24BPP: row_len = (3 * w + 3) / 4 * 4;
            default:   row_len = 4 * w;
        endcase
        return row_len * h;
    endfunction

    // returns at a rising edge once every word is taken and every pixel seen
    task automatic wait_idle();
        @(negedge clk);
        while (words_taken != words_queued || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // writes format, width and height in turn; the spare index is poked last on request
    task automatic set_regs(logic [DIM_BITS-1:0] fmt_word, logic [DIM_BITS-1:0] width,
                            logic [DIM_BITS-1:0] height, bit poke_spare);
        cfg_idx_t            ids [4];
        logic [DIM_BITS-1:0] vals [4];
        int                  n;
        ids[0] = REG_FORMAT;
        ids[1] = REG_WIDTH;
        ids[2] = REG_HEIGHT;
        ids[3] = REG_SPARE;
        vals[0] = fmt_word;
        vals[1] = width;
        vals[2] = height;
        vals[3] = DIM_BITS'($urandom);
        n = poke_spare ? 4 : 3;
        for (int i = 0; i < n; i++)
        begin
            @(negedge clk);
            cfg.valid <= 1'b1;
            cfg.index <= ids[i];
            cfg.data <= vals[i];
            @(posedge clk);
            while (!(cfg.valid && cfg.ready))
                @(posedge clk);
            apply_reg(ids[i], vals[i]);
        end
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
        gen_fmt = fmt_word[FMT_BITS-1:0];
    endtask

    // one image with random content, sometimes cut short or followed by stray bytes
    task automatic send_image(fmt_t f, int w, int h, bit pause_mid, output int sent);
        int total;
        int roll;
        total = image_bytes(f, w, h);
        sent = total;
        roll = $urandom_range(0, 5);
        if (roll == 0)
            sent = $urandom_range(1, total);
        else if (roll == 1)
            sent = total + $urandom_range(1, 3);
        for (int i = 0; i < sent; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                add_palette(PIDX_BITS'($urandom), PCOLOR_BITS'($urandom));
            add_byte(BYTE_BITS'($urandom));
            // sender stops until the pixels so far have all come out
            if (pause_mid && i == sent / 2)
                wait_idle();
        end
        if (sent > total)
            sent = total;
    endtask

    always @(posedge clk)
    begin : word_taker
        if (pix_in.valid && pix_in.ready)
        begin
            in_took = 1'b1;
            words_taken++;
            unpack_word(offered_word);
        end
    end

    always @(negedge clk)
    begin : word_driver
        if (in_took)
        begin
            in_took = 1'b0;
            offering = 1'b0;
            in_wait = $urandom_range(0, in_gap_max);
        end
        if (!offering && rst_n)
        begin
            if (in_wait > 0)
            begin
                in_wait--;
                pix_in.valid <= 1'b0;
            end
            else if (word_queue.size() > 0)
            begin
                offered_word = word_queue.pop_front();
                pix_in.valid <= 1'b1;
                pix_in.func <= offered_word.func;
                pix_in.data_byte <= offered_word.data;
                pix_in.palette_index <= offered_word.pidx;
                pix_in.palette_color <= offered_word.pcolor;
                offering = 1'b1;
            end
            else
                pix_in.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : pixel_monitor
        pixel_t want;
        if (pix_out.valid && pix_out.ready)
        begin
            out_took = 1'b1;
            if (expected_pixels.size() == 0)
                report("pixel with nothing expected", '0, pix_out.pixel_color);
            else
            begin
                want = expected_pixels.pop_front();
                if (pix_out.pixel_color !== want.color)
                    report("pixel_color", want.color, pix_out.pixel_color);
                if (pix_out.pixel_column !== want.column)
                    report("pixel_column", PIXEL_BITS'(want.column), PIXEL_BITS'(pix_out.pixel_column));
                if (pix_out.pixel_row !== want.row)
                    report("pixel_row", PIXEL_BITS'(want.row), PIXEL_BITS'(pix_out.pixel_row));
                if (pix_out.last_of_run !== want.last_run)
                    report("last_of_run", PIXEL_BITS'(want.last_run), PIXEL_BITS'(pix_out.last_of_run));
                if (pix_out.last_of_image !== want.last_image)
                    report("last_of_image", PIXEL_BITS'(want.last_image),
                           PIXEL_BITS'(pix_out.last_of_image));
            end
        end
    end

    always @(negedge clk)
    begin : pixel_sink
        if (out_took)
        begin
            out_took = 1'b0;
            out_wait = $urandom_range(0, out_gap_max);
        end
        if (long_hold)
        begin
            long_hold = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pix_out.ready <= 1'b0;
        end
        else if (out_wait > 0)
        begin
            out_wait--;
            pix_out.ready <= 1'b0;
        end
        else
            pix_out.ready <= 1'b1;
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)
                || (cfg.valid && cfg.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        int   w;
        int   h;
        int   sent;
        int   n_bytes;
        bit   first;
        fmt_t f;

        rst_n = 1'b0;
        pix_in.valid = 1'b0;
        pix_in.func = FUNC_PIXEL;
        pix_in.data_byte = '0;
        pix_in.palette_index = '0;
        pix_in.palette_color = '0;
        pix_out.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_FORMAT;
        cfg.data = '0;
        cur_fmt = FMT_8BPP;
        cur_width = 1;
        cur_height = 1;
        apply_reg(REG_FORMAT, DIM_BITS'(FMT_8BPP));
        gen_fmt = FMT_8BPP;
        in_gap_max = 0;
        out_gap_max = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // reset size: one pixel, then a stray byte past the end of the image
        add_palette(8'h00, 24'h000000);
        add_palette(8'hFF, 24'hFFFFFF);
        add_byte(8'hFF);
        add_byte(8'h00);
        wait_idle();

        // 1 bpp with a width that leaves bits unused in the last byte of a row
        set_regs(DIM_BITS'(FMT_1BPP), 13'd10, 13'd2, 1'b1);
        add_byte(8'hA5); add_byte(8'hFF); add_byte(8'h00); add_byte(8'h5A);
        wait_idle();

        // 4 bpp, odd width
        set_regs(DIM_BITS'(FMT_4BPP), 13'd3, 13'd1, 1'b0);
        add_byte(8'hF0); add_byte(8'h0F);
        wait_idle();

        // 24 bpp, one pad byte per row
        set_regs(DIM_BITS'(FMT_24BPP), 13'd1, 13'd2, 1'b0);
        add_byte(8'hFF); add_byte(8'h00); add_byte(8'h80); add_byte(8'h3C);
        add_byte(8'h01); add_byte(8'h7F); add_byte(8'hFE); add_byte(8'hC3);
        wait_idle();

        // 32 bpp with a palette write in the middle of the pixel
        set_regs(DIM_BITS'(FMT_32BPP), 13'd1, 13'd1, 1'b0);
        add_byte(8'h00); add_byte(8'hFF);
        add_palette(8'h80, 24'h123456);
        add_byte(8'hAA); add_byte(8'h55);
        wait_idle();

        // undefined format, upper data bits set: bytes dropped
        set_regs({10'h3FF, FMT_UNDEF_LAST}, 13'd4, 13'd4, 1'b0);
        add_byte(8'h12); add_byte(8'h34);
        wait_idle();

        // zero sizes count as one
        set_regs(DIM_BITS'(FMT_8BPP), 13'd0, 13'd0, 1'b0);
        add_byte(8'h00);
        wait_idle();

        // oversize width clamps to the coordinate range
        set_regs({10'h155, FMT_8BPP}, 13'h1FFF, DIM_BITS'(DIM_MAX), 1'b0);
        add_byte(8'hFF); add_byte(8'h00);
        wait_idle();

        // 1 bpp image while the output side holds off for a long stretch
        in_gap_max = MAX_GAP;
        out_gap_max = MAX_GAP;
        set_regs(DIM_BITS'(FMT_1BPP), 13'd64, 13'd2, 1'b0);
        long_hold = 1'b1;
        repeat (16) add_byte(BYTE_BITS'($urandom));
        wait_idle();

        // random small images
        n_bytes = 0;
        first = 1'b1;
        while (n_bytes < RANDOM_BYTES)
        begin
            in_gap_max = $urandom_range(0, 1) ? MAX_GAP : 0;
            out_gap_max = $urandom_range(0, 1) ? MAX_GAP : 0;
            if ($urandom_range(0, 9) == 0)
            begin
                f = fmt_t'($urandom_range(FMT_UNDEF_FIRST, FMT_UNDEF_LAST));
                set_regs({10'($urandom), f}, DIM_BITS'($urandom_range(1, 8)),
                         DIM_BITS'($urandom_range(1, 8)), 1'b0);
                repeat (3) add_byte(BYTE_BITS'($urandom));
            end
            else
            begin
                f = fmt_t'($urandom_range(FMT_1BPP, FMT_32BPP));
                case (f)
                    FMT_1BPP:  w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24)
                                                               : 8 * $urandom_range(1, 3);
                    FMT_4BPP:  w = $urandom_range(1, 9);
                    FMT_8BPP:  w = $urandom_range(1, 7);
                    FMT_24BPP: w = $urandom_range(1, 4);
                    default:   w = $urandom_range(1, 3);
                endcase
                h = $urandom_range(1, 3);
                set_regs(DIM_BITS'(f), DIM_BITS'(w), DIM_BITS'(h), 1'b0);
                send_image(f, w, h, first, sent);
                n_bytes += sent;
                first = 1'b0;
            end
            wait_idle();
        end

        repeat (SETTLE) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
design/bpu_pkg.sv
design/bpu_in_if.sv
design/bpu_out_if.sv
design/bpu_cfg_if.sv
design/bitmap_pixel_unpacker_top.sv
test/tb_bitmap_pixel_unpacker_top.sv
